>>> sv/qwt_pkg.sv
// Package for the quoted word tokenizer.
// Holds character codes, the tokenizer state and result types and the blank test.
// No dependencies.
package qwt_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic in_single_quote;
    logic in_double_quote;
    logic escape_pending;
    logic word_open;
  } qwt_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       word_end;
  } qwt_result_t;

  function automatic logic qwt_is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

>>> sv/qwt_step.sv
// Combinational step of the quoted word tokenizer: one byte and the current
// quote/escape/word state give the next state and at most one result.
// Depends on qwt_pkg.
module qwt_step import qwt_pkg::*; (
  input  logic [7:0]  byte_i,
  input  qwt_state_t  state_i,
  output qwt_state_t  state_o,
  output qwt_result_t result_o
);

  qwt_result_t word_byte;
  qwt_result_t word_break;
  qwt_result_t no_result;

  always_comb begin
    no_result  = '0;
    word_byte  = '0;
    word_byte.valid      = 1'b1;
    word_byte.first_byte = byte_i;
    word_byte.byte_count = 2'd1;
    word_break = '0;
    word_break.valid    = 1'b1;
    word_break.word_end = 1'b1;
  end

  always_comb begin
    logic drop;
    drop     = 1'b0;
    state_o  = state_i;
    result_o = no_result;

    if (byte_i == CH_NUL) begin
      // end of line: clear everything, close an open word
      state_o = '0;
      if (state_i.word_open) begin
        result_o = word_break;
      end
    end else if (state_i.escape_pending) begin
      state_o.escape_pending = 1'b0;
      state_o.word_open      = 1'b1;
      if (state_i.in_single_quote) begin
        drop = (byte_i == CH_BSLASH) || (byte_i == CH_SQUOTE);
      end else if (state_i.in_double_quote) begin
        drop = (byte_i == CH_BSLASH) || (byte_i == CH_DQUOTE);
      end else begin
        drop = (byte_i == CH_BSLASH) || (byte_i == CH_SQUOTE) ||
               (byte_i == CH_DQUOTE) || qwt_is_white(byte_i);
      end
      if (drop) begin
        result_o = word_byte;
      end else begin
        result_o             = word_byte;
        result_o.first_byte  = CH_BSLASH;
        result_o.second_byte = byte_i;
        result_o.byte_count  = 2'd2;
      end
    end else if (!state_i.word_open && qwt_is_white(byte_i)) begin
      result_o = no_result;
    end else if (!state_i.word_open && byte_i == CH_SEMI) begin
      // empty word, stay in the skipping state
      result_o = word_break;
    end else begin
      state_o.word_open = 1'b1;
      if (byte_i == CH_BSLASH) begin
        state_o.escape_pending = 1'b1;
      end else if (state_i.in_single_quote) begin
        if (byte_i == CH_SQUOTE) begin
          state_o.in_single_quote = 1'b0;
        end else begin
          result_o = word_byte;
        end
      end else if (state_i.in_double_quote) begin
        if (byte_i == CH_DQUOTE) begin
          state_o.in_double_quote = 1'b0;
        end else begin
          result_o = word_byte;
        end
      end else if (byte_i == CH_SQUOTE) begin
        state_o.in_single_quote = 1'b1;
      end else if (byte_i == CH_DQUOTE) begin
        state_o.in_double_quote = 1'b1;
      end else if (qwt_is_white(byte_i) || byte_i == CH_SEMI) begin
        state_o.word_open = 1'b0;
        result_o          = word_break;
      end else begin
        result_o = word_byte;
      end
    end
  end

endmodule

>>> sv/quoted_word_tokenizer.sv
// Quoted word tokenizer, top level: input register, step logic, result register.
// An accepted byte is held in the input register, passes the step logic and lands in the result register.
// Throughput: one byte per cycle while out_ready stays high; a held result stalls the
// input register, and in_ready follows out_ready combinationally when both are full.
// Reset (rst_n low, synchronous): both stages empty, quote/escape/word state cleared.
// Depends on qwt_pkg and qwt_step.
module quoted_word_tokenizer import qwt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic [1:0] out_byte_count,
  output logic       out_word_end
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  qwt_state_t  state_r;
  qwt_state_t  state_nxt;
  qwt_result_t step_res;
  qwt_result_t res_r;
  qwt_result_t res_nxt;
  logic        res_free;
  logic        advance;

  qwt_step u_step (
    .byte_i   (in_byte_r),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  assign res_free = !res_r.valid || out_ready;
  assign advance  = in_vld_r && res_free;
  assign in_ready = !in_vld_r || res_free;

  always_comb begin
    res_nxt       = step_res;
    res_nxt.valid = advance && step_res.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= '0;
      res_r    <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (in_valid && in_ready) begin
        in_byte_r <= in_byte;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      // load a new result or drop the one just taken
      if (res_free) begin
        res_r <= res_nxt;
      end
    end
  end

  assign out_valid       = res_r.valid;
  assign out_first_byte  = res_r.first_byte;
  assign out_second_byte = res_r.second_byte;
  assign out_byte_count  = res_r.byte_count;
  assign out_word_end    = res_r.word_end;

endmodule

>>> tb/testbench.sv
// Testbench for quoted_word_tokenizer: directed and random byte streams with
// a word tracker that predicts every result and checks it. Depends on qwt_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qwt_pkg::*;

  class word_tracker;
    qwt_state_t  st;
    qwt_result_t due[$];
    int          errors;
    int          counted;

    function new();
      st = '0;
      errors = 0;
      counted = 0;
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Advance the tokenizer state by one accepted byte; queue any result.
    function void note_byte(logic [7:0] c);
      qwt_result_t r;
      bit          give;
      bit          drop;
      r = '0;
      r.valid = 1'b1;
      give = 1'b0;
      drop = 1'b0;
      if (c == CH_NUL) begin
        give = st.word_open;
        r.word_end = 1'b1;
        st = '0;
      end else if (st.escape_pending) begin
        st.escape_pending = 1'b0;
        st.word_open = 1'b1;
        if (st.in_single_quote) drop = c == CH_BSLASH || c == CH_SQUOTE;
        else if (st.in_double_quote) drop = c == CH_BSLASH || c == CH_DQUOTE;
        else drop = c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE || is_blank(c);
        give = 1'b1;
        if (drop) begin
          r.first_byte = c;
          r.byte_count = 2'd1;
        end else begin
          r.first_byte = CH_BSLASH;
          r.second_byte = c;
          r.byte_count = 2'd2;
        end
      end else if (!st.word_open && is_blank(c)) begin
        // leading blank: consume, no result
      end else if (!st.word_open && c == CH_SEMI) begin
        // empty word, still skipping afterwards
        give = 1'b1;
        r.word_end = 1'b1;
      end else begin
        st.word_open = 1'b1;
        if (c == CH_BSLASH) begin
          st.escape_pending = 1'b1;
        end else if (st.in_single_quote) begin
          if (c == CH_SQUOTE) st.in_single_quote = 1'b0;
          else give = 1'b1;
        end else if (st.in_double_quote) begin
          if (c == CH_DQUOTE) st.in_double_quote = 1'b0;
          else give = 1'b1;
        end else if (c == CH_SQUOTE) begin
          st.in_single_quote = 1'b1;
        end else if (c == CH_DQUOTE) begin
          st.in_double_quote = 1'b1;
        end else if (is_blank(c) || c == CH_SEMI) begin
          st.word_open = 1'b0;
          give = 1'b1;
          r.word_end = 1'b1;
        end else begin
          give = 1'b1;
        end
        if (give && !r.word_end) begin
          r.first_byte = c;
          r.byte_count = 2'd1;
        end
      end
      if (give) due.push_back(r);
      counted++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] wanted);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, wanted, $time);
      errors++;
    endtask

    task check_piece(logic [7:0] first, logic [7:0] second, logic [1:0] count,
                     logic last);
      qwt_result_t want;
      if (due.size() == 0) begin
        report("result with none due", 32'({first, second, count, last}), 0);
        return;
      end
      want = due.pop_front();
      if (first !== want.first_byte) begin
        report("first_byte", 32'(first), 32'(want.first_byte));
      end
      if (second !== want.second_byte) begin
        report("second_byte", 32'(second), 32'(want.second_byte));
      end
      if (count !== want.byte_count) begin
        report("byte_count", 32'(count), 32'(want.byte_count));
      end
      if (last !== want.word_end) begin
        report("word_end", 32'(last), 32'(want.word_end));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_first_byte;
  logic [7:0]  out_second_byte;
  logic [1:0]  out_byte_count;
  logic        out_word_end;
  bit          steady = 1'b0;
  word_tracker tracker;

  quoted_word_tokenizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_first_byte (out_first_byte),
    .out_second_byte(out_second_byte),
    .out_byte_count (out_byte_count),
    .out_word_end   (out_word_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || $urandom_range(99) >= 37;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.note_byte(in_byte);
    if (rst_n && out_valid && out_ready) begin
      tracker.check_piece(out_first_byte, out_second_byte, out_byte_count, out_word_end);
    end
  end

  task automatic send_byte(logic [7:0] b);
    // drop valid for a random gap before the item
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (word_tracker::is_blank(c) || c == CH_SEMI || c == CH_BSLASH ||
           c == CH_SQUOTE || c == CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    int k = $urandom_range(0, 5);
    return k == 5 ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] pick_escapee();
    case ($urandom_range(0, 5))
      0: return CH_BSLASH;
      1: return CH_SQUOTE;
      2: return CH_DQUOTE;
      3: return pick_blank();
      4: return CH_SEMI;
      default: return pick_plain();
    endcase
  endfunction

  task automatic send_quoted(logic [7:0] q);
    send_byte(q);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_BSLASH);
        send_byte(pick_escapee());
      end else begin
        case ($urandom_range(0, 4))
          0: send_byte(pick_blank());
          1: send_byte(CH_SEMI);
          2: send_byte(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
          default: send_byte(pick_plain());
        endcase
      end
    end
    send_byte(q);
  endtask

  task automatic send_line();
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 2)) send_byte(pick_blank());
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_byte(pick_plain());
          4, 5: begin
            send_byte(CH_BSLASH);
            send_byte(pick_escapee());
          end
          6, 7: send_quoted(CH_SQUOTE);
          default: send_quoted(CH_DQUOTE);
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_byte(pick_blank());
        5, 6, 7: send_byte(CH_SEMI);
        default: ;
      endcase
    end
    // break some lines: leave a quote open or an escape hanging at the zero byte
    case ($urandom_range(0, 19))
      0: send_byte(CH_SQUOTE);
      1: send_byte(CH_DQUOTE);
      2: send_byte(CH_BSLASH);
      default: ;
    endcase
    send_byte(CH_NUL);
  endtask

  initial begin
    int base;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // blanks and line end with no word open, an empty word and a word ended by a semicolon
    send_byte(CH_NUL);
    for (int c = 9; c <= 13; c++) send_byte(8'(c));
    send_byte(CH_SPACE);
    send_text(";");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text(";");
    // escapes outside quotes, then a tab ends the word
    send_text("\\\\\\ \\a\t");
    send_text("'\\'\\\";'");
    send_text("\"\\\"\\'\"\\");
    send_byte(CH_NUL);

    base = tracker.counted;
    while (tracker.counted - base < 650) begin
      steady <= tracker.counted - base >= 250 && tracker.counted - base < 400;
      if ($urandom_range(0, 9) < 8) begin
        send_line();
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;
    steady <= 1'b0;

    // let the last accepted item reach the tracker before draining
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
